### rtl/mbps_pkg.sv
package mbps_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 6;
  localparam int PLEN_W      = 7;
  localparam int ADDR_W      = 64;
  localparam int IN_TDATA_W  = 24;

  typedef enum logic [0:0] {
    REG_PATTERN_LENGTH = 1'b0,
    REG_BASE_ADDRESS   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              wc;
    logic [BYTE_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic rot_up;
    logic rot_dn;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } result_t;

endpackage

### rtl/mbps_cell.sv
module mbps_cell (
  input  logic                             clk,
  input  mbps_pkg::cell_ctl_t              ctl,
  input  logic                             sel,
  input  logic                             active,
  input  logic [mbps_pkg::BYTE_W-1:0]      byte_in,
  output logic [mbps_pkg::BYTE_W-1:0]      byte_out,
  input  mbps_pkg::entry_t                 load_ent,
  input  mbps_pkg::entry_t                 from_lo,
  input  mbps_pkg::entry_t                 from_hi,
  output mbps_pkg::entry_t                 ent_out,
  output logic                             match
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] win_r;
  entry_t            ent_r;

  // window byte moves one cell older per scanned byte
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= byte_in;
    end
  end

  // pattern ring: rotate to follow the length, or take a load
  always_ff @(posedge clk) begin
    if (ctl.rot_up) begin
      ent_r <= from_lo;
    end else if (ctl.rot_dn) begin
      ent_r <= from_hi;
    end else if (ctl.load && sel) begin
      ent_r <= load_ent;
    end
  end

  assign byte_out = win_r;
  assign ent_out  = ent_r;
  assign match    = !active || ent_r.wc || (ent_r.val == byte_in);

endmodule

### rtl/masked_byte_pattern_scanner.sv
// result: a scan byte that completes a region's first match, or ends a region with no
//   match reported, has its result registered into the out register or the skid slot
// throughput: one item per cycle, set by the combinational compare across the cell row;
//   the input stalls while the skid slot is full or while a pattern_length write
//   rotates the ring to the new length, one ring rotation step per cycle
// reset: synchronous; clears flags, fill count and base, sets the length to 1, not the pattern entries
module masked_byte_pattern_scanner #(
  parameter int MAX_LEN = mbps_pkg::MAX_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mbps_pkg::IN_TDATA_W-1:0]    in_tdata,  // entry_index, pattern_byte,
                                                        // is_wildcard, data_byte, zero pad
  input  logic                               in_tuser,  // req_type
  input  logic                               in_tlast,  // region_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mbps_pkg::ADDR_W-1:0]        out_tdata, // match_address
  output logic                               out_tuser, // found
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [mbps_pkg::ADDR_W-1:0]        cfg_data
);
  import mbps_pkg::*;

  localparam int NW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW = ((NW > IDX_W) ? NW : IDX_W) + 1;
  localparam int EW = (NW > PLEN_W) ? NW : PLEN_W;

  // input fields
  logic [IDX_W-1:0]  entry_index;
  entry_t            load_ent;
  logic [BYTE_W-1:0] data_byte;

  assign entry_index  = in_tdata[5:0];
  assign load_ent.val = in_tdata[13:6];
  assign load_ent.wc  = in_tdata[14];
  assign data_byte    = in_tdata[22:15];

  // control and config state
  logic [NW-1:0]     tgt_n_r, tgt_n_nxt;
  logic [NW-1:0]     aligned_r, aligned_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] bmn_r, bmn_nxt;
  logic [ADDR_W-1:0] cnt_p1_r, cnt_p1_nxt;
  logic [NW-1:0]     fill_r, fill_nxt;
  logic              rep_r, rep_nxt;
  logic              out_v_r, out_v_nxt;
  result_t           out_d_r, out_d_nxt;
  logic              skid_v_r, skid_v_nxt;
  result_t           skid_d_r, skid_d_nxt;

  logic              in_acc, scan, load;
  logic              rotating;
  logic [EW-1:0]     plen_e;
  logic [NW-1:0]     plen_n;
  logic [DW-1:0]     a_m1, idx_e, diff;
  logic [IW-1:0]     load_cell;
  logic              load_ok;
  logic [NW-1:0]     fill_inc;
  logic              hit;
  logic              res_v;
  result_t           res;
  cell_ctl_t         ctl;

  logic   [MAX_LEN-1:0] match_v;
  logic   [MAX_LEN-1:0] load_sel;
  logic   [MAX_LEN-1:0] active;
  logic   [BYTE_W-1:0]  win_in  [MAX_LEN];
  logic   [BYTE_W-1:0]  win_q   [MAX_LEN];
  entry_t               ent_q   [MAX_LEN];

  assign cfg_ready = 1'b1;
  assign rotating  = (aligned_r != tgt_n_r);
  assign in_tready = !skid_v_r && !rotating;
  assign in_acc    = in_tvalid && in_tready;
  assign scan      = in_acc && in_tuser;
  assign load      = in_acc && !in_tuser;

  // clamp the written length into 1..MAX_LEN
  always_comb begin
    plen_e = EW'(cfg_data[PLEN_W-1:0]);
    if (plen_e == '0) begin
      plen_n = NW'(1);
    end else if (plen_e > EW'(MAX_LEN)) begin
      plen_n = NW'(MAX_LEN);
    end else begin
      plen_n = plen_e[NW-1:0];
    end
  end

  always_comb begin
    tgt_n_nxt = tgt_n_r;
    base_nxt  = base_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: tgt_n_nxt = plen_n;
        REG_BASE_ADDRESS:   base_nxt  = cfg_data;
      endcase
    end
    bmn_nxt = base_nxt - ADDR_W'(tgt_n_nxt);
  end

  // pattern entry i lives in cell (n-1-i) mod MAX_LEN
  always_comb begin
    a_m1  = DW'(aligned_r) - DW'(1);
    idx_e = DW'(entry_index);
    diff  = a_m1 - idx_e;
    if (idx_e > a_m1) begin
      diff = diff + DW'(MAX_LEN);
    end
    load_cell = diff[IW-1:0];
    load_ok   = (idx_e < DW'(MAX_LEN));
  end

  always_comb begin
    ctl.shift  = scan;
    ctl.rot_up = rotating && (aligned_r < tgt_n_r);
    ctl.rot_dn = rotating && (aligned_r > tgt_n_r);
    ctl.load   = load && load_ok;
  end

  genvar j;
  generate
    for (j = 0; j < MAX_LEN; j++) begin : g_cell
      if (j == 0) begin : g_head
        assign win_in[j] = data_byte;
      end else begin : g_body
        assign win_in[j] = win_q[j-1];
      end
      assign load_sel[j] = (load_cell == IW'(j));
      assign active[j]   = (NW'(j) < aligned_r);

      mbps_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .sel      (load_sel[j]),
        .active   (active[j]),
        .byte_in  (win_in[j]),
        .byte_out (win_q[j]),
        .load_ent (load_ent),
        .from_lo  (ent_q[(j + MAX_LEN - 1) % MAX_LEN]),
        .from_hi  (ent_q[(j + 1) % MAX_LEN]),
        .ent_out  (ent_q[j]),
        .match    (match_v[j])
      );
    end
  endgenerate

  assign fill_inc = (fill_r == NW'(MAX_LEN)) ? fill_r : fill_r + NW'(1);
  assign hit      = (&match_v) && (fill_inc >= aligned_r);
  assign res_v    = scan && !rep_r && (hit || in_tlast);
  assign res.found = hit;
  assign res.addr  = hit ? (bmn_r + cnt_p1_r) : '0;

  // region bookkeeping
  always_comb begin
    aligned_nxt = aligned_r;
    if (ctl.rot_up) begin
      aligned_nxt = aligned_r + NW'(1);
    end else if (ctl.rot_dn) begin
      aligned_nxt = aligned_r - NW'(1);
    end
    fill_nxt   = fill_r;
    cnt_p1_nxt = cnt_p1_r;
    rep_nxt    = rep_r;
    if (scan) begin
      if (in_tlast) begin
        fill_nxt   = '0;
        cnt_p1_nxt = ADDR_W'(1);
        rep_nxt    = 1'b0;
      end else begin
        fill_nxt   = fill_inc;
        cnt_p1_nxt = cnt_p1_r + ADDR_W'(1);
        rep_nxt    = rep_r || hit;
      end
    end
  end

  // output register with skid slot
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = res_v;
        out_d_nxt = res;
      end
    end else if (res_v) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_n_r   <= NW'(1);
      aligned_r <= NW'(1);
      base_r    <= '0;
      bmn_r     <= '1;
      cnt_p1_r  <= ADDR_W'(1);
      fill_r    <= '0;
      rep_r     <= 1'b0;
      out_v_r   <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      tgt_n_r   <= tgt_n_nxt;
      aligned_r <= aligned_nxt;
      base_r    <= base_nxt;
      bmn_r     <= bmn_nxt;
      cnt_p1_r  <= cnt_p1_nxt;
      fill_r    <= fill_nxt;
      rep_r     <= rep_nxt;
      out_v_r   <= out_v_nxt;
      skid_v_r  <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r.addr;
  assign out_tuser  = out_d_r.found;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full while output register empty");

  a_no_input_while_rotating: assert property (@(posedge clk) disable iff (!rst_n)
    (aligned_r != tgt_n_r) |-> !in_tready)
    else $error("input taken while pattern ring misaligned");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |=> out_v_r)
    else $error("result dropped");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NW'(MAX_LEN))
    else $error("fill count beyond window depth");

endmodule
